[sv/pmbf_pkg.sv]
// ----------------------------------------------------------------------------
// pmbf_pkg
// Shared codes, field widths, defaults and types of the multi-channel
// pseudo-terminal byte FIFO block.
// ----------------------------------------------------------------------------
package pmbf_pkg;

   localparam int PTY_MAX_DEF   = 8;
   localparam int BUF_DEPTH_DEF = 1024;
   localparam int VT_COUNT_DEF  = 12;

   localparam int FUNC_W   = 3;
   localparam int CHAN_W   = 4;
   localparam int BYTE_W   = 8;
   localparam int VT_W     = 5;
   localparam int STATUS_W = 3;

   // Operation codes.
   localparam logic [FUNC_W-1:0] FN_CREATE = 3'd0;
   localparam logic [FUNC_W-1:0] FN_MWRITE = 3'd1;
   localparam logic [FUNC_W-1:0] FN_MREAD  = 3'd2;
   localparam logic [FUNC_W-1:0] FN_SWRITE = 3'd3;
   localparam logic [FUNC_W-1:0] FN_SREAD  = 3'd4;
   localparam logic [FUNC_W-1:0] FN_ATTACH = 3'd5;
   localparam logic [FUNC_W-1:0] FN_MAPGET = 3'd6;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_BAD    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOPAIR = 3'd4;

   localparam logic [VT_W-1:0] VT_NONE = 5'h1F;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [CHAN_W-1:0] channel_id;
      logic [BYTE_W-1:0] data_byte;
      logic [VT_W-1:0]   term_index;
      logic              transfer_last;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VT_W-1:0]     value;
      logic                wr_m2s;
      logic                wr_s2m;
      logic                rd_m2s;
      logic                rd_s2m;
   } op_result_type;

endpackage

[sv/multi_channel_pty_byte_fifo_top.sv]
// ----------------------------------------------------------------------------
// multi_channel_pty_byte_fifo_top
// Channel-pair byte FIFO block: request sequencing, byte stores, response
// register.
// ----------------------------------------------------------------------------
// Each request yields exactly one response. A create, write, attach or map
// lookup is executed in the cycle after it is accepted unless the response
// slot is still full, and the block takes the next request in that same
// cycle, so such requests sustain one per cycle while responses are taken. A
// read issues the store access in its execute cycle and forms its response
// once the registered store read returns and the slot is free; the next
// request is taken only then. The response register decouples the two sides:
// a request can be accepted while an earlier response still waits. Both byte
// stores start undefined and need no clearing: only occupied bytes are read.
module multi_channel_pty_byte_fifo_top
   import pmbf_pkg::*;
#(
   parameter int PTY_MAX   = PTY_MAX_DEF,
   parameter int BUF_DEPTH = BUF_DEPTH_DEF,
   parameter int VT_COUNT  = VT_COUNT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [FUNC_W-1:0]     req_func,
   input  logic [CHAN_W-1:0]     req_channel_id,
   input  logic [BYTE_W-1:0]     req_data_byte,
   input  logic signed [VT_W-1:0] req_term_index,
   input  logic                  req_transfer_last,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [BYTE_W-1:0]     rsp_read_byte,
   output logic signed [VT_W-1:0] rsp_value,
   output logic                  rsp_transfer_done
);

   localparam int DEPTH = PTY_MAX * BUF_DEPTH;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_READ = 2'd2;

   logic [1:0]          state_ff, state_in;
   req_type             req_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [BYTE_W-1:0]   rsp_byte_ff;
   logic [VT_W-1:0]     rsp_value_ff;
   logic                rsp_done_ff;

   op_result_type       res;
   logic [AW-1:0]       mem_addr;
   logic [BYTE_W-1:0]   m2s_rdata;
   logic [BYTE_W-1:0]   s2m_rdata;
   logic                slot_free;
   logic                rd_any;
   logic                commit;
   logic                load_exec;
   logic                load_read;
   logic                accept;

   pmbf_chan_table #(
      .PTY_MAX  (PTY_MAX),
      .BUF_DEPTH(BUF_DEPTH),
      .VT_COUNT (VT_COUNT),
      .AW       (AW)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ff),
      .commit  (commit),
      .res     (res),
      .mem_addr(mem_addr)
   );

   pmbf_ram #(
      .DEPTH(DEPTH),
      .AW   (AW)
   ) u_m2s_ram (
      .clock(clock),
      .en   (commit && (res.wr_m2s || res.rd_m2s)),
      .we   (res.wr_m2s),
      .addr (mem_addr),
      .wdata(req_ff.data_byte),
      .rdata(m2s_rdata)
   );

   pmbf_ram #(
      .DEPTH(DEPTH),
      .AW   (AW)
   ) u_s2m_ram (
      .clock(clock),
      .en   (commit && (res.wr_s2m || res.rd_s2m)),
      .we   (res.wr_s2m),
      .addr (mem_addr),
      .wdata(req_ff.data_byte),
      .rdata(s2m_rdata)
   );

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign rd_any    = res.rd_m2s || res.rd_s2m;
   // A read commits at once; any other request waits for a free response slot.
   assign commit    = (state_ff == S_EXEC) && (rd_any || slot_free);
   assign load_exec = commit && !rd_any;
   assign load_read = (state_ff == S_READ) && slot_free;
   assign req_ready = (state_ff == S_IDLE) || load_exec || load_read;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            state_in = accept ? S_EXEC : S_IDLE;
         end
         S_EXEC: begin
            if (commit) begin
               if (rd_any) begin
                  state_in = S_READ;
               end else begin
                  state_in = accept ? S_EXEC : S_IDLE;
               end
            end
         end
         S_READ: begin
            if (slot_free) begin
               state_in = accept ? S_EXEC : S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = (load_exec || load_read) ? 1'b1 : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff.func          <= req_func;
         req_ff.channel_id    <= req_channel_id;
         req_ff.data_byte     <= req_data_byte;
         req_ff.term_index    <= req_term_index;
         req_ff.transfer_last <= req_transfer_last;
      end
      if (load_exec) begin
         rsp_status_ff <= res.status;
         rsp_byte_ff   <= '0;
         rsp_value_ff  <= res.value;
         rsp_done_ff   <= req_ff.transfer_last;
      end else if (load_read) begin
         // The request register still holds the read while its data returns.
         rsp_status_ff <= ST_OK;
         rsp_byte_ff   <= (req_ff.func == FN_MREAD) ? s2m_rdata : m2s_rdata;
         rsp_value_ff  <= VT_NONE;
         rsp_done_ff   <= req_ff.transfer_last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_read_byte     = rsp_byte_ff;
   assign rsp_value         = $signed(rsp_value_ff);
   assign rsp_transfer_done = rsp_done_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ((load_exec || load_read) && rsp_valid_ff) |-> rsp_ready)
      else $error("pending response overwritten");

   a_read_follows_exec: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> ($past(state_ff) == S_EXEC || $past(state_ff) == S_READ))
      else $error("read data state entered without an issued read");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_EXEC))
      else $error("accepted request not executed");

   a_read_wait: assert property (@(posedge clock) disable iff (reset)
      (commit && rd_any) |=> (state_ff == S_READ))
      else $error("store read issued without waiting for its data");

endmodule

[sv/pmbf_ram.sv]
// ----------------------------------------------------------------------------
// pmbf_ram
// Single-port byte store with a registered read, one access per cycle.
// ----------------------------------------------------------------------------
module pmbf_ram
   import pmbf_pkg::*;
#(
   parameter int DEPTH = PTY_MAX_DEF * BUF_DEPTH_DEF,
   parameter int AW    = $clog2(PTY_MAX_DEF * BUF_DEPTH_DEF)
) (
   input  logic              clock,
   input  logic              en,
   input  logic              we,
   input  logic [AW-1:0]     addr,
   input  logic [BYTE_W-1:0] wdata,
   output logic [BYTE_W-1:0] rdata
);

   logic [BYTE_W-1:0] store_mem [DEPTH];
   logic [BYTE_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            store_mem[addr] <= wdata;
         end else begin
            rdata_ff <= store_mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

[sv/pmbf_chan_table.sv]
// ----------------------------------------------------------------------------
// pmbf_chan_table
// Pair table, FIFO pointers and terminal map. Decodes the held request,
// produces its status and store access, and commits the state change.
// ----------------------------------------------------------------------------
module pmbf_chan_table
   import pmbf_pkg::*;
#(
   parameter int PTY_MAX   = PTY_MAX_DEF,
   parameter int BUF_DEPTH = BUF_DEPTH_DEF,
   parameter int VT_COUNT  = VT_COUNT_DEF,
   parameter int AW        = $clog2(PTY_MAX_DEF * BUF_DEPTH_DEF)
) (
   input  logic          clock,
   input  logic          reset,
   input  req_type       req,
   input  logic          commit,
   output op_result_type res,
   output logic [AW-1:0] mem_addr
);

   localparam int PW  = $clog2(2 * BUF_DEPTH);
   localparam int LW  = PW + 1;
   localparam int CHW = (PTY_MAX > 1) ? $clog2(PTY_MAX) : 1;
   localparam int VW  = (VT_COUNT > 1) ? $clog2(VT_COUNT) : 1;

   logic [PTY_MAX-1:0] in_use_ff;
   logic [PW-1:0]      m2s_head_ff [PTY_MAX];
   logic [PW-1:0]      m2s_tail_ff [PTY_MAX];
   logic [PW-1:0]      s2m_head_ff [PTY_MAX];
   logic [PW-1:0]      s2m_tail_ff [PTY_MAX];
   logic [VT_W-1:0]    map_ff      [VT_COUNT];

   logic [CHW-1:0]     ch_idx;
   logic               ch_ok;
   logic               side_m2s;
   logic               is_write;
   logic [PW-1:0]      head;
   logic [PW-1:0]      tail;
   logic [LW-1:0]      level;
   logic               full;
   logic               empty;
   logic [PW-1:0]      use_ptr;
   logic [PW-1:0]      slot;
   logic [PW-1:0]      next_ptr;
   logic               free_found;
   logic [CHW-1:0]     free_idx;
   logic signed [VT_W-1:0] vt;
   logic               vt_low;
   logic               vt_neg1;
   logic               vt_in_map;
   logic [VW-1:0]      vt_idx;
   logic [VT_W-1:0]    ch_entry;
   logic               do_create;
   logic               do_attach;

   assign ch_idx   = req.channel_id[CHW-1:0];
   assign ch_ok    = ({1'b0, req.channel_id} < 5'(PTY_MAX)) && in_use_ff[ch_idx];
   assign ch_entry = {1'b0, req.channel_id};

   // The master writes the m2s queue and the slave reads it.
   assign side_m2s = (req.func == FN_MWRITE) || (req.func == FN_SREAD);
   assign is_write = (req.func == FN_MWRITE) || (req.func == FN_SWRITE);
   assign head     = side_m2s ? m2s_head_ff[ch_idx] : s2m_head_ff[ch_idx];
   assign tail     = side_m2s ? m2s_tail_ff[ch_idx] : s2m_tail_ff[ch_idx];

   // Pointers run modulo twice the depth so that full and empty differ.
   assign level = (head >= tail) ? ({1'b0, head} - {1'b0, tail})
                                 : ({1'b0, head} + LW'(2 * BUF_DEPTH) - {1'b0, tail});
   assign full  = level >= LW'(BUF_DEPTH);
   assign empty = head == tail;

   assign use_ptr  = is_write ? head : tail;
   assign slot     = (use_ptr >= PW'(BUF_DEPTH)) ? use_ptr - PW'(BUF_DEPTH) : use_ptr;
   assign next_ptr = (use_ptr == PW'(2 * BUF_DEPTH - 1)) ? '0 : use_ptr + PW'(1);
   assign mem_addr = AW'(ch_idx) * AW'(BUF_DEPTH) + AW'(slot);

   // Lowest free pair.
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = PTY_MAX - 1; i >= 0; i--) begin
         if (!in_use_ff[i]) begin
            free_found = 1'b1;
            free_idx   = CHW'(i);
         end
      end
   end

   assign vt        = $signed(req.term_index);
   assign vt_low    = vt < -5'sd1;
   assign vt_neg1   = vt == -5'sd1;
   assign vt_in_map = !req.term_index[VT_W-1] && (req.term_index[3:0] < 4'(VT_COUNT));
   assign vt_idx    = req.term_index[VW-1:0];

   always_comb begin
      res        = '0;
      res.status = ST_OK;
      res.value  = VT_NONE;
      do_create  = 1'b0;
      do_attach  = 1'b0;
      unique case (req.func) inside
         FN_CREATE: begin
            if (free_found) begin
               res.value = VT_W'(free_idx);
               do_create = 1'b1;
            end else begin
               res.status = ST_NOPAIR;
            end
         end
         FN_MWRITE, FN_SWRITE: begin
            if (!ch_ok) begin
               res.status = ST_BAD;
            end else if (full) begin
               res.status = ST_FULL;
            end else begin
               res.wr_m2s = side_m2s;
               res.wr_s2m = !side_m2s;
            end
         end
         FN_MREAD, FN_SREAD: begin
            if (!ch_ok) begin
               res.status = ST_BAD;
            end else if (empty) begin
               res.status = ST_EMPTY;
            end else begin
               res.rd_m2s = side_m2s;
               res.rd_s2m = !side_m2s;
            end
         end
         FN_ATTACH: begin
            if (!ch_ok || vt_low) begin
               res.status = ST_BAD;
            end else begin
               do_attach = 1'b1;
            end
         end
         FN_MAPGET: begin
            if (vt_in_map) begin
               res.value = map_ff[vt_idx];
            end
         end
         default: begin
            res.status = ST_BAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff <= '0;
         for (int i = 0; i < PTY_MAX; i++) begin
            m2s_head_ff[i] <= '0;
            m2s_tail_ff[i] <= '0;
            s2m_head_ff[i] <= '0;
            s2m_tail_ff[i] <= '0;
         end
         for (int i = 0; i < VT_COUNT; i++) begin
            map_ff[i] <= VT_NONE;
         end
      end else if (commit) begin
         if (do_create) begin
            in_use_ff[free_idx]   <= 1'b1;
            m2s_head_ff[free_idx] <= '0;
            m2s_tail_ff[free_idx] <= '0;
            s2m_head_ff[free_idx] <= '0;
            s2m_tail_ff[free_idx] <= '0;
         end
         if (res.wr_m2s) begin
            m2s_head_ff[ch_idx] <= next_ptr;
         end
         if (res.wr_s2m) begin
            s2m_head_ff[ch_idx] <= next_ptr;
         end
         if (res.rd_m2s) begin
            m2s_tail_ff[ch_idx] <= next_ptr;
         end
         if (res.rd_s2m) begin
            s2m_tail_ff[ch_idx] <= next_ptr;
         end
         if (do_attach) begin
            if (vt_neg1) begin
               // Detach clears every terminal that names this channel.
               for (int i = 0; i < VT_COUNT; i++) begin
                  if (map_ff[i] == ch_entry) begin
                     map_ff[i] <= VT_NONE;
                  end
               end
            end else if (vt_in_map) begin
               map_ff[vt_idx] <= ch_entry;
            end
         end
      end
   end

endmodule
